/* sv/dgrr_pkg.sv */
// Shared types, constants and the glyph font for the digit glyph row renderer.
`timescale 1ns / 1ps
`default_nettype none
package dgrr_pkg;

    // Region modes.
    localparam logic [1:0] MODE_FULL  = 2'd0;
    localparam logic [1:0] MODE_UPPER = 2'd1;
    localparam logic [1:0] MODE_LOWER = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Glyph codes in the font table.
    localparam logic [4:0] GLYPH_DASH = 5'd20;
    localparam logic [4:0] GLYPH_S    = 5'd21;
    localparam logic [4:0] GLYPH_L    = 5'd22;
    localparam logic [4:0] GLYPH_H    = 5'd23;
    localparam logic [4:0] GLYPH_I    = 5'd24;
    localparam logic [4:0] SMALL_BASE = 5'd10;
    localparam int         GLYPH_COUNT = 25;

    // Raw input codes for the special values.
    localparam logic [10:0] CODE_SL = 11'h7FC;
    localparam logic [10:0] CODE_HI = 11'h7FB;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // One classified item, as handed from the front to the back.
    typedef struct packed {
        logic       three_digit;
        logic [1:0] mode;
        logic [4:0] glyph_a;
        logic [4:0] glyph_b;
        logic [4:0] glyph_c;
    } dgrr_entry_t;

    // 8x8 digits 0..9, 5x8 digits 10..19, then dash, S, L, H, I.
    localparam logic [7:0] FONT_ROM [0:GLYPH_COUNT-1][0:7] = '{
        '{8'h3c, 8'h42, 8'h42, 8'h42, 8'h42, 8'h42, 8'h42, 8'h3c},
        '{8'h10, 8'h30, 8'h70, 8'h10, 8'h10, 8'h10, 8'h10, 8'h7c},
        '{8'h3c, 8'h42, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h7e},
        '{8'h3c, 8'h42, 8'h02, 8'h0c, 8'h02, 8'h02, 8'h42, 8'h3c},
        '{8'h08, 8'h18, 8'h28, 8'h48, 8'hfe, 8'h08, 8'h08, 8'h3e},
        '{8'h7e, 8'h40, 8'h40, 8'h7c, 8'h02, 8'h02, 8'h42, 8'h3c},
        '{8'h1c, 8'h20, 8'h40, 8'h7c, 8'h42, 8'h42, 8'h42, 8'h3c},
        '{8'h7c, 8'h44, 8'h08, 8'h08, 8'h10, 8'h10, 8'h20, 8'h20},
        '{8'h3c, 8'h42, 8'h42, 8'h3c, 8'h42, 8'h42, 8'h42, 8'h3c},
        '{8'h3c, 8'h42, 8'h42, 8'h42, 8'h3e, 8'h02, 8'h04, 8'h38},
        '{8'h60, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h60},
        '{8'h20, 8'h20, 8'h60, 8'h20, 8'h20, 8'h20, 8'h20, 8'h70},
        '{8'h60, 8'h90, 8'h10, 8'h20, 8'h20, 8'h40, 8'h40, 8'hf0},
        '{8'h60, 8'h90, 8'h10, 8'h20, 8'h10, 8'h10, 8'h90, 8'h60},
        '{8'h20, 8'h60, 8'h60, 8'ha0, 8'hf0, 8'h20, 8'h20, 8'h70},
        '{8'hf0, 8'h80, 8'h80, 8'he0, 8'h10, 8'h10, 8'h90, 8'h60},
        '{8'h70, 8'h80, 8'h80, 8'he0, 8'h90, 8'h90, 8'h90, 8'h60},
        '{8'hf0, 8'h90, 8'h10, 8'h10, 8'h20, 8'h20, 8'h20, 8'h20},
        '{8'h60, 8'h90, 8'h90, 8'h60, 8'h90, 8'h90, 8'h90, 8'h60},
        '{8'h60, 8'h90, 8'h90, 8'h90, 8'h70, 8'h10, 8'h20, 8'h60},
        '{8'h00, 8'h00, 8'h00, 8'h7e, 8'h7e, 8'h00, 8'h00, 8'h00},
        '{8'h3e, 8'h40, 8'h40, 8'h40, 8'h3c, 8'h02, 8'h02, 8'h7c},
        '{8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h3c},
        '{8'h42, 8'h42, 8'h42, 8'h42, 8'h7e, 8'h42, 8'h42, 8'h42},
        '{8'h00, 8'h00, 8'h10, 8'h00, 8'h10, 8'h10, 8'h10, 8'h38}
    };

    // One row of one glyph; codes past the table read as blank.
    function automatic logic [7:0] font_row(input logic [4:0] glyph, input logic [2:0] grow);
        logic [7:0] bits;
        bits = 8'h00;
        if (int'(glyph) < GLYPH_COUNT)
        begin
            bits = FONT_ROM[glyph][grow];
        end
        return bits;
    endfunction

endpackage
`default_nettype wire

/* sv/dgrr_front.sv */
// Front part: accepts items and splits the value into glyph codes.
`timescale 1ns / 1ps
`default_nettype none
module dgrr_front
    import dgrr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [10:0] value,
    input  wire logic        [1:0]  mode,
    output logic                    busy,
    input  wire logic               queue_full,
    output logic                    push,
    output dgrr_entry_t             push_entry
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_QUOT = 4'b0010,
        F_REM  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [10:0]  raw_reg, raw_next;
    logic [1:0]   mode_reg, mode_next;
    logic [3:0]   quot_reg, quot_next;
    logic [6:0]   rem_reg, rem_next;

    logic [22:0]  quot_prod;
    logic [10:0]  hundreds_sub;
    logic [10:0]  rem_full;
    logic [14:0]  tens_prod;
    logic [3:0]   tens;
    logic [6:0]   units_full;
    logic [3:0]   digit_h;
    logic         negative;

    assign busy = (state_reg != F_IDLE);

    // Hundreds by reciprocal multiply: exact for all 10-bit magnitudes.
    assign quot_prod    = {13'd0, raw_reg[9:0]} * 23'd5243;
    assign hundreds_sub = 11'({7'd0, quot_reg} * 11'd100);
    assign rem_full     = {1'b0, raw_reg[9:0]} - hundreds_sub;

    // Tens and units from the remainder below one hundred.
    assign tens_prod  = {8'd0, rem_reg} * 15'd205;
    assign tens       = tens_prod[14:11];
    assign units_full = rem_reg - {tens[3:0], 3'b000} - {2'b00, tens, 1'b0};
    assign digit_h    = (quot_reg == 4'd10) ? 4'd0 : quot_reg;
    assign negative   = raw_reg[10];

    // Classify the item into font indices.
    always_comb
    begin
        push_entry.mode = mode_reg;
        if (negative)
        begin
            push_entry.three_digit = 1'b0;
            push_entry.glyph_a     = 5'd0;
            if (raw_reg == CODE_SL)
            begin
                push_entry.glyph_b = GLYPH_S;
                push_entry.glyph_c = GLYPH_L;
            end
            else if (raw_reg == CODE_HI)
            begin
                push_entry.glyph_b = GLYPH_H;
                push_entry.glyph_c = GLYPH_I;
            end
            else
            begin
                push_entry.glyph_b = GLYPH_DASH;
                push_entry.glyph_c = GLYPH_DASH;
            end
        end
        else if (digit_h != 4'd0)
        begin
            push_entry.three_digit = 1'b1;
            push_entry.glyph_a     = {1'b0, digit_h} + SMALL_BASE;
            push_entry.glyph_b     = {1'b0, tens} + SMALL_BASE;
            push_entry.glyph_c     = {1'b0, units_full[3:0]} + SMALL_BASE;
        end
        else
        begin
            push_entry.three_digit = 1'b0;
            push_entry.glyph_a     = 5'd0;
            push_entry.glyph_b     = {1'b0, tens};
            push_entry.glyph_c     = {1'b0, units_full[3:0]};
        end
    end

    assign push = (state_reg == F_PUSH) && !queue_full;

    // Sequencer over the division steps.
    always_comb
    begin
        state_next = state_reg;
        raw_next   = raw_reg;
        mode_next  = mode_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    raw_next   = value;
                    mode_next  = mode;
                    state_next = F_QUOT;
                end
            end
            F_QUOT:
            begin
                quot_next  = quot_prod[22:19];
                state_next = F_REM;
            end
            F_REM:
            begin
                rem_next   = rem_full[6:0];
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!queue_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg  <= raw_next;
        mode_reg <= mode_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

endmodule
`default_nettype wire

/* sv/dgrr_queue.sv */
// Short queue of classified items between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module dgrr_queue
    import dgrr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire dgrr_entry_t push_entry,
    output logic       full,
    input  wire logic  pop,
    output logic       empty,
    output dgrr_entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dgrr_entry_t        slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

/* sv/dgrr_back.sv */
// Back part: walks the rows of one classified item and emits them.
`timescale 1ns / 1ps
`default_nettype none
module dgrr_back
    import dgrr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  empty,
    input  wire dgrr_entry_t head,
    output logic       pop,
    output logic       valid,
    output logic [3:0] row_index,
    output logic [15:0] row_bits,
    output logic       last
);

    dgrr_entry_t entry_reg, entry_next;
    logic        active_reg, active_next;
    logic [3:0]  n_reg, n_next;
    logic        valid_reg;
    logic [3:0]  row_index_reg, row_index_next;
    logic [15:0] row_bits_reg, row_bits_next;
    logic        last_reg, last_next;

    logic [3:0]  last_n;
    logic        is_last;
    logic [2:0]  grow;
    logic [3:0]  first_row;
    logic [7:0]  row_a, row_b, row_c;
    logic [7:0]  hi, lo;

    // Row count and run end for the current item.
    assign last_n  = (entry_reg.mode == MODE_FULL) ? 4'd15 : 4'd7;
    assign is_last = active_reg && (n_reg == last_n);
    assign pop     = !empty && (!active_reg || is_last);

    // Bottom glyph row first; full mode shows each glyph row twice.
    assign grow      = 3'd7 - ((entry_reg.mode == MODE_FULL) ? n_reg[3:1] : n_reg[2:0]);
    assign first_row = (entry_reg.mode == MODE_UPPER) ? 4'd8 : 4'd0;

    assign row_a = font_row(entry_reg.glyph_a, grow);
    assign row_b = font_row(entry_reg.glyph_b, grow);
    assign row_c = font_row(entry_reg.glyph_c, grow);

    // Pack the glyphs into the two bytes, then invert.
    always_comb
    begin
        if (entry_reg.three_digit)
        begin
            hi = row_a | (row_b >> 5);
            lo = (row_b << 3) | (row_c >> 2);
        end
        else
        begin
            hi = row_b;
            lo = row_c;
        end
        row_bits_next  = ~{hi, lo};
        row_index_next = first_row + n_reg;
        last_next      = is_last;
    end

    // Row sequencer; the next item loads on the last row of this one.
    always_comb
    begin
        entry_next  = entry_reg;
        active_next = active_reg;
        n_next      = n_reg;
        if (pop)
        begin
            entry_next  = head;
            active_next = (head.mode != MODE_NONE);
            n_next      = 4'd0;
        end
        else if (active_reg)
        begin
            n_next = n_reg + 1'b1;
            if (is_last)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            n_reg      <= 4'd0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= active_reg;
            n_reg      <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg     <= entry_next;
        row_index_reg <= row_index_next;
        row_bits_reg  <= row_bits_next;
        last_reg      <= last_next;
    end

    assign valid     = valid_reg;
    assign row_index = row_index_reg;
    assign row_bits  = row_bits_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire

/* sv/digit_glyph_row_renderer.sv */
// Path: the front registers the input, quotient and remainder, then pushes the item into the
// queue; the back loads it and registers each row. Rows of an item follow one per cycle.
// The front is busy until it has pushed its item, waiting while the queue is full; the row
// sequencer in the back emits 16 rows per item in full mode and 8 in a half mode. A mode 3 item emits nothing.
// Reset clears the front sequencer, the queue and the row sequencer; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module digit_glyph_row_renderer
    import dgrr_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [10:0] value,
    input  wire logic        [1:0]  mode,
    output logic                    valid,
    output logic             [3:0]  row_index,
    output logic             [15:0] row_bits,
    output logic                    last
);

    logic        queue_full;
    logic        queue_empty;
    logic        push;
    logic        pop;
    dgrr_entry_t push_entry;
    dgrr_entry_t head;

    // Accept and classify.
    dgrr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value      (value),
        .mode       (mode),
        .busy       (busy),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decoupling queue.
    dgrr_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .empty      (queue_empty),
        .head       (head)
    );

    // Row emission.
    dgrr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (queue_empty),
        .head      (head),
        .pop       (pop),
        .valid     (valid),
        .row_index (row_index),
        .row_bits  (row_bits),
        .last      (last)
    );

endmodule
`default_nettype wire

/* tb/digit_glyph_row_renderer_tb.sv */
// Self-checking testbench for the digit glyph row renderer: predicts every emitted row.
`timescale 1ns / 1ps
module digit_glyph_row_renderer_tb;
    import dgrr_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 30;
    localparam int MAX_REPORTS  = 10;

    // Glyph art: 8x8 digits, 5x8 digits, then dash, S, L, H and I.
    localparam logic [7:0] GLYPH_ART [0:24][0:7] = '{
        '{8'h3c, 8'h42, 8'h42, 8'h42, 8'h42, 8'h42, 8'h42, 8'h3c},
        '{8'h10, 8'h30, 8'h70, 8'h10, 8'h10, 8'h10, 8'h10, 8'h7c},
        '{8'h3c, 8'h42, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h7e},
        '{8'h3c, 8'h42, 8'h02, 8'h0c, 8'h02, 8'h02, 8'h42, 8'h3c},
        '{8'h08, 8'h18, 8'h28, 8'h48, 8'hfe, 8'h08, 8'h08, 8'h3e},
        '{8'h7e, 8'h40, 8'h40, 8'h7c, 8'h02, 8'h02, 8'h42, 8'h3c},
        '{8'h1c, 8'h20, 8'h40, 8'h7c, 8'h42, 8'h42, 8'h42, 8'h3c},
        '{8'h7c, 8'h44, 8'h08, 8'h08, 8'h10, 8'h10, 8'h20, 8'h20},
        '{8'h3c, 8'h42, 8'h42, 8'h3c, 8'h42, 8'h42, 8'h42, 8'h3c},
        '{8'h3c, 8'h42, 8'h42, 8'h42, 8'h3e, 8'h02, 8'h04, 8'h38},
        '{8'h60, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h60},
        '{8'h20, 8'h20, 8'h60, 8'h20, 8'h20, 8'h20, 8'h20, 8'h70},
        '{8'h60, 8'h90, 8'h10, 8'h20, 8'h20, 8'h40, 8'h40, 8'hf0},
        '{8'h60, 8'h90, 8'h10, 8'h20, 8'h10, 8'h10, 8'h90, 8'h60},
        '{8'h20, 8'h60, 8'h60, 8'ha0, 8'hf0, 8'h20, 8'h20, 8'h70},
        '{8'hf0, 8'h80, 8'h80, 8'he0, 8'h10, 8'h10, 8'h90, 8'h60},
        '{8'h70, 8'h80, 8'h80, 8'he0, 8'h90, 8'h90, 8'h90, 8'h60},
        '{8'hf0, 8'h90, 8'h10, 8'h10, 8'h20, 8'h20, 8'h20, 8'h20},
        '{8'h60, 8'h90, 8'h90, 8'h60, 8'h90, 8'h90, 8'h90, 8'h60},
        '{8'h60, 8'h90, 8'h90, 8'h90, 8'h70, 8'h10, 8'h20, 8'h60},
        '{8'h00, 8'h00, 8'h00, 8'h7e, 8'h7e, 8'h00, 8'h00, 8'h00},
        '{8'h3e, 8'h40, 8'h40, 8'h40, 8'h3c, 8'h02, 8'h02, 8'h7c},
        '{8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h3c},
        '{8'h42, 8'h42, 8'h42, 8'h42, 8'h7e, 8'h42, 8'h42, 8'h42},
        '{8'h00, 8'h00, 8'h10, 8'h00, 8'h10, 8'h10, 8'h10, 8'h38}
    };

    // Directed items: field extremes, every mode and the special codes.
    localparam int DIRECTED_COUNT = 24;
    localparam int DIRECTED_NUMS [0:DIRECTED_COUNT-1] = '{
        0, 9, 10, 99, 100, 101, 555, 999, 1000, 1023, -3, -4,
        -5, -4, -5, -3, -1, -2, -1024, -6, 7, -4, 500, 42
    };
    localparam logic [1:0] DIRECTED_MODES [0:DIRECTED_COUNT-1] = '{
        MODE_FULL, MODE_UPPER, MODE_LOWER, MODE_FULL, MODE_UPPER, MODE_LOWER,
        MODE_FULL, MODE_UPPER, MODE_LOWER, MODE_FULL, MODE_FULL, MODE_UPPER,
        MODE_LOWER, MODE_FULL, MODE_FULL, MODE_UPPER, MODE_LOWER, MODE_FULL,
        MODE_UPPER, MODE_LOWER, MODE_NONE, MODE_NONE, MODE_NONE, MODE_FULL
    };

    typedef struct {
        logic signed [10:0] num;
        logic [1:0]         region;
        int                 gap_pct;
        bit                 drain;
    } draw_cmd_t;

    typedef struct {
        logic [3:0]  index;
        logic [15:0] bits;
        logic        tail;
    } bitmap_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic signed [10:0]      value = '0;
    logic [1:0]              mode = MODE_FULL;
    logic                    busy;
    logic                    valid;
    logic [3:0]              row_index;
    logic [15:0]             row_bits;
    logic                    last;

    draw_cmd_t   draw_cmds [$];
    bitmap_row_t pending_rows [$];
    bit          cmd_taken = 1'b0;
    int          fail_count = 0;
    int          quiet_cycles = 0;

    digit_glyph_row_renderer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .mode      (mode),
        .valid     (valid),
        .row_index (row_index),
        .row_bits  (row_bits),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the rows that one command draws and queue them in emission order.
    function automatic void render_rows(input logic signed [10:0] num, input logic [1:0] region);
        logic [10:0] raw;
        logic [4:0]  hund, tens, ones;
        logic [2:0]  glyph_row;
        logic [7:0]  left, right, tens_art;
        int          base_row, row_count, scale, u;
        bitmap_row_t row;
        raw = num;
        if (raw[10])
        begin
            // Negative: only the two special codes have glyphs, the rest show dashes.
            hund = 5'd0;
            if (raw == CODE_SL)
            begin
                tens = GLYPH_S;
                ones = GLYPH_L;
            end
            else if (raw == CODE_HI)
            begin
                tens = GLYPH_H;
                ones = GLYPH_I;
            end
            else
            begin
                tens = GLYPH_DASH;
                ones = GLYPH_DASH;
            end
        end
        else
        begin
            u    = int'(raw);
            hund = 5'((u / 100) % 10);
            tens = 5'((u / 10) % 10);
            ones = 5'(u % 10);
        end
        case (region)
            MODE_FULL:
            begin
                base_row = 0;
                row_count = 16;
                scale = 2;
            end
            MODE_UPPER:
            begin
                base_row = 8;
                row_count = 8;
                scale = 1;
            end
            MODE_LOWER:
            begin
                base_row = 0;
                row_count = 8;
                scale = 1;
            end
            default:
            begin
                base_row = 0;
                row_count = 0;
                scale = 1;
            end
        endcase
        for (int n = 0; n < row_count; n++)
        begin
            // Bottom glyph row is drawn first.
            glyph_row = 3'(7 - n / scale);
            if (hund != 5'd0)
            begin
                tens_art = GLYPH_ART[tens + SMALL_BASE][glyph_row];
                left  = GLYPH_ART[hund + SMALL_BASE][glyph_row] | (tens_art >> 5);
                right = (tens_art << 3) | (GLYPH_ART[ones + SMALL_BASE][glyph_row] >> 2);
            end
            else
            begin
                left  = GLYPH_ART[tens][glyph_row];
                right = GLYPH_ART[ones][glyph_row];
            end
            row.index = 4'(base_row + n);
            row.bits  = ~{left, right};
            row.tail  = (n == row_count - 1);
            pending_rows.push_back(row);
        end
    endfunction

    function automatic logic signed [10:0] pick_number();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            v = int'($urandom_range(0, 99));
        else if (sel < 65)
            v = int'($urandom_range(100, 999));
        else if (sel < 82)
            v = -3 - int'($urandom_range(0, 2));
        else if (sel < 93)
            v = -int'($urandom_range(1, 1024));
        else
            v = int'($urandom_range(1000, 1023));
        return v[10:0];
    endfunction

    function automatic logic [1:0] pick_region();
        if ($urandom_range(0, 99) < 8)
            return MODE_NONE;
        return 2'($urandom_range(0, 2));
    endfunction

    task automatic add_cmd(input logic signed [10:0] num, input logic [1:0] region,
                           input int gap_pct, input bit drain);
        draw_cmd_t cmd;
        cmd.num     = num;
        cmd.region  = region;
        cmd.gap_pct = gap_pct;
        cmd.drain   = drain;
        draw_cmds.push_back(cmd);
    endtask

    task automatic add_random_phase(input int count, input int gap_pct);
        for (int i = 0; i < count; i++)
        begin
            add_cmd(pick_number(), pick_region(), gap_pct,
                    i == 0 || $urandom_range(0, 99) < 3);
        end
    endtask

    // Command driver: present the next command at the falling edge, hold it until
    // the transfer, and idle at random; a drain command waits for all rows first.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || cmd_taken)
        begin
            if (draw_cmds.size() != 0
                && !(draw_cmds[0].drain && pending_rows.size() != 0)
                && $urandom_range(0, 99) >= draw_cmds[0].gap_pct)
            begin
                start <= 1'b1;
                value <= draw_cmds[0].num;
                mode  <= draw_cmds[0].region;
                void'(draw_cmds.pop_front());
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check each row strobe against the oldest expected row, then
    // record a command transfer and predict its rows.
    always @(posedge clk)
    begin : watch_bus
        bitmap_row_t want;
        if (valid)
        begin
            if (pending_rows.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: row with nothing expected: idx %0d bits %h last %b",
                             $time, row_index, row_bits, last);
            end
            else
            begin
                want = pending_rows.pop_front();
                if (row_index !== want.index || row_bits !== want.bits || last !== want.tail)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: row mismatch: expected idx %0d bits %h last %b, got idx %0d bits %h last %b",
                                 $time, want.index, want.bits, want.tail,
                                 row_index, row_bits, last);
                end
            end
        end
        cmd_taken = rst_n && start && !busy;
        if (cmd_taken)
            render_rows(value, mode);
        if (cmd_taken || valid)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Watchdog: too long without any transfer or row ends the run.
    always @(negedge clk)
    begin
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        // Directed commands first, then three random phases with different idling.
        for (int i = 0; i < DIRECTED_COUNT; i++)
            add_cmd(DIRECTED_NUMS[i][10:0], DIRECTED_MODES[i], 0, 1'b0);
        add_random_phase(150, 14);
        add_random_phase(150, 56);
        add_random_phase(146, 0);

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every command to be taken and every row to arrive.
        while (draw_cmds.size() != 0 || start)
            @(negedge clk);
        while (pending_rows.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
        fail_count += pending_rows.size();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
